>>> src/wsu_pkg.sv
// Package for the word sorter unit: key width, cell control struct, state
// enum and the letter/key conversion functions. No dependencies.
package wsu_pkg;

    localparam int LETTERS_MAX  = 10;
    localparam int KEY_W        = LETTERS_MAX * 8;
    localparam int MAX_WORDS_DF = 64;
    localparam int LETTERS_DF   = 10;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // One operation per cycle for the whole row of cells
    typedef struct packed {
        logic ins;       // insert the broadcast key in sorted position
        logic shift_dn;  // every cell takes its upper neighbor
        logic shift_up;  // every cell takes its lower neighbor
    } cell_op_t;

    // Stream word (letter 0 in the low byte) to compare key (letter 0 in
    // the high byte). Bytes from the first zero on, and bytes at or above
    // the letter count, become zero, so a plain unsigned compare of keys
    // matches the string order.
    function automatic logic [KEY_W-1:0] to_key(input logic [KEY_W-1:0] word,
                                                input int letters);
        logic [KEY_W-1:0] key;
        logic             ended;
        logic [7:0]       b;
        key   = '0;
        ended = 1'b0;
        for (int i = 0; i < LETTERS_MAX; i++) begin
            b = word[i*8 +: 8];
            if (i >= letters || b == 8'd0) begin
                ended = 1'b1;
            end
            key[(LETTERS_MAX-1-i)*8 +: 8] = ended ? 8'd0 : b;
        end
        return key;
    endfunction

    // Compare key back to stream word order
    function automatic logic [KEY_W-1:0] from_key(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] word;
        word = '0;
        for (int i = 0; i < LETTERS_MAX; i++) begin
            word[i*8 +: 8] = key[(LETTERS_MAX-1-i)*8 +: 8];
        end
        return word;
    endfunction

endpackage

>>> src/wsu_cell.sv
// One insertion cell of the word sorter: holds one key and its valid flag.
// Depends on wsu_pkg.
module wsu_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wsu_pkg::cell_op_t        op,
    input  logic [wsu_pkg::KEY_W-1:0] new_key,
    input  logic [wsu_pkg::KEY_W-1:0] lo_key,
    input  logic                     lo_valid,
    input  logic                     lo_precedes,
    input  logic [wsu_pkg::KEY_W-1:0] hi_key,
    input  logic                     hi_valid,
    output logic [wsu_pkg::KEY_W-1:0] key,
    output logic                     valid,
    output logic                     precedes
);

    logic [wsu_pkg::KEY_W-1:0] key_reg, key_next;
    logic                      valid_reg, valid_next;

    // New key belongs at or below this cell; an empty cell always accepts
    assign precedes = !valid_reg || (new_key < key_reg);

    always_comb begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (op.ins) begin
            if (lo_precedes) begin
                key_next   = lo_key;
                valid_next = lo_valid;
            end else if (precedes) begin
                key_next   = new_key;
                valid_next = 1'b1;
            end
        end else if (op.shift_dn) begin
            key_next   = hi_key;
            valid_next = hi_valid;
        end else if (op.shift_up) begin
            key_next   = lo_key;
            valid_next = lo_valid;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign key   = key_reg;
    assign valid = valid_reg;

endmodule

>>> src/word_sorter_unit.sv
// Word sorter top level: a row of insertion cells plus load/drain control
// and the output register. Depends on wsu_pkg and wsu_cell.
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+--------------------------------
//  s_ (word) | in        | s_tvalid/s_tready  | s_tdata letters, s_tlast last_word
//  m_ (word) | out       | m_tvalid/m_tready  | m_tdata letters, m_tlast out_last
//  cfg_      | in        | cfg_wr_en          | cfg_wr_data sort_descending
//
// Loading takes one word per cycle: all cells compare the broadcast key at
// once and the row shifts open at the insert point in the same cycle.
// After the word with s_tlast, the row drains one word per cycle while the output
// register is free: ascending from the bottom cell, descending from the top cell
// (the row first shifts up until the largest word reaches the top cell).
// s_tready is low while draining and rises once the final word sits in the
// output register. A stalled m_tready holds the output register and holds the
// row once a word waits to leave; a descending drain keeps shifting up until
// the top cell fills.
// Reset (synchronous, aresetn low) empties every cell and clears the order bit.
module word_sorter_unit #(
    parameter int MAX_WORDS    = wsu_pkg::MAX_WORDS_DF,
    parameter int WORD_LETTERS = wsu_pkg::LETTERS_DF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [wsu_pkg::KEY_W-1:0] s_tdata,   // letter_0 [7:0] .. letter_9 [79:72]
    input  logic                      s_tlast,   // last_word
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [wsu_pkg::KEY_W-1:0] m_tdata,   // out_letter_0 [7:0] .. out_letter_9 [79:72]
    output logic                      m_tlast,   // out_last
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data // sort_descending
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int KW    = wsu_pkg::KEY_W;

    wsu_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              desc_reg;

    logic [KW-1:0]     m_tdata_reg, m_tdata_next;
    logic              m_tlast_reg, m_tlast_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [KW-1:0]     new_key;
    logic [KW-1:0]     cell_key      [MAX_WORDS];
    logic              cell_valid    [MAX_WORDS];
    logic              cell_precedes [MAX_WORDS];

    wsu_pkg::cell_op_t op;
    logic              s_xfer;
    logic              full;
    logic              out_free;
    logic              emit;
    logic [KW-1:0]     end_key;

    assign new_key  = wsu_pkg::to_key(s_tdata, WORD_LETTERS);
    assign full     = (cnt_reg == CNT_W'(MAX_WORDS));
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    // Ascending drains from the bottom cell, descending from the top cell
    assign end_key  = desc_reg ? cell_key[MAX_WORDS-1] : cell_key[0];

    // Row of insertion cells; edge cells see empty neighbors
    for (genvar g = 0; g < MAX_WORDS; g++) begin : g_cell
        logic [KW-1:0] lo_key, hi_key;
        logic          lo_valid, lo_precedes, hi_valid;
        if (g == 0) begin : g_lo_edge
            assign lo_key      = '0;
            assign lo_valid    = 1'b0;
            assign lo_precedes = 1'b0;
        end else begin : g_lo_link
            assign lo_key      = cell_key[g-1];
            assign lo_valid    = cell_valid[g-1];
            assign lo_precedes = cell_precedes[g-1];
        end
        if (g == MAX_WORDS - 1) begin : g_hi_edge
            assign hi_key   = '0;
            assign hi_valid = 1'b0;
        end else begin : g_hi_link
            assign hi_key   = cell_key[g+1];
            assign hi_valid = cell_valid[g+1];
        end
        wsu_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op),
            .new_key     (new_key),
            .lo_key      (lo_key),
            .lo_valid    (lo_valid),
            .lo_precedes (lo_precedes),
            .hi_key      (hi_key),
            .hi_valid    (hi_valid),
            .key         (cell_key[g]),
            .valid       (cell_valid[g]),
            .precedes    (cell_precedes[g])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wsu_pkg::ST_LOAD: begin
                if (s_xfer && s_tlast) begin
                    state_next = wsu_pkg::ST_DRAIN;
                end
            end
            wsu_pkg::ST_DRAIN: begin
                // Return to loading once the final word moves out of the row
                if (emit && cnt_reg == CNT_W'(1)) begin
                    state_next = wsu_pkg::ST_LOAD;
                end
            end
            default: state_next = wsu_pkg::ST_LOAD;
        endcase
    end

    // Outputs of the control: ready, cell operation, emit
    always_comb begin
        s_tready = 1'b0;
        op       = '0;
        emit     = 1'b0;
        case (state_reg)
            wsu_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                // Drop words that arrive with the row full
                op.ins   = s_xfer && !full;
            end
            wsu_pkg::ST_DRAIN: begin
                if (desc_reg) begin
                    emit        = cell_valid[MAX_WORDS-1] && out_free;
                    // Advance freely until the top cell holds a word
                    op.shift_up = emit || !cell_valid[MAX_WORDS-1];
                end else begin
                    emit        = out_free;
                    op.shift_dn = emit;
                end
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (op.ins) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (emit) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Output register
    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit) begin
            m_tdata_next  = wsu_pkg::from_key(end_key);
            m_tlast_next  = (cnt_reg == CNT_W'(1));
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wsu_pkg::ST_LOAD;
            cnt_reg      <= '0;
            desc_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                desc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> src/wsu_checker.sv
// Port-level checks for the word sorter unit, bound to the top level.
// Depends on word_sorter_unit ports only.
module wsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Drop ready only after the last word of a set
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $fell(s_tready) |-> $past(s_tvalid && s_tlast))
        else $error("ready fell without a last word transfer");

    // Ready returns together with the final result of the run
    a_ready_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(s_tready) |-> m_tvalid && m_tlast)
        else $error("ready rose without a final result");

    // A word that ends at the first letter is all zero
    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:0] == 8'd0 |-> m_tdata[79:8] == 72'd0)
        else $error("letters after the end are not zero");

endmodule

bind word_sorter_unit wsu_checker u_wsu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
